// File: design/des_pkg.sv
// Shared types and constants for the dependency event scheduler.
package des_pkg;

    localparam int OP_W        = 3;
    localparam int EV_W        = 6;
    localparam int DELAY_W     = 32;
    localparam int MASK_W      = 64;
    localparam int TICK_OUT_W  = 64;
    localparam int ST_W        = 3;
    localparam int EXEC_W      = 32;

    localparam int IN_TUSER_W  = OP_W;
    localparam int IN_EV_LSB   = 0;
    localparam int IN_SEC_LSB  = IN_EV_LSB + EV_W;
    localparam int IN_DLY_LSB  = IN_SEC_LSB + EV_W;
    localparam int IN_MASK_LSB = IN_DLY_LSB + DELAY_W;
    localparam int IN_USED_W   = IN_MASK_LSB + MASK_W;
    localparam int IN_TDATA_W  = ((IN_USED_W + 7) / 8) * 8;

    localparam int OUT_EV_LSB   = 0;
    localparam int OUT_TICK_LSB = OUT_EV_LSB + EV_W;
    localparam int OUT_ST_LSB   = OUT_TICK_LSB + TICK_OUT_W;
    localparam int OUT_EXEC_LSB = OUT_ST_LSB + ST_W;
    localparam int OUT_USED_W   = OUT_EXEC_LSB + EXEC_W;
    localparam int OUT_TDATA_W  = ((OUT_USED_W + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_SCHED    = 3'd0,
        OP_OVER     = 3'd1,
        OP_PAUSE    = 3'd2,
        OP_NEXT     = 3'd3,
        OP_COMPLETE = 3'd4,
        OP_SKIP     = 3'd5
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK      = 3'd0,
        ST_DUP     = 3'd1,
        ST_SELF    = 3'd2,
        ST_EMPTY   = 3'd3,
        ST_REFUSED = 3'd4,
        ST_FULL    = 3'd5
    } status_t;

    typedef enum logic [4:0] {
        UOP_NONE,
        UOP_LATCH,
        UOP_SCHED_PUSH,
        UOP_SKIP,
        UOP_SCAN_INIT,
        UOP_Q_RD_IDX,
        UOP_FIND_CMP,
        UOP_W_RD_B,
        UOP_OVER_W_WR,
        UOP_OVER_FIN,
        UOP_P_W_WR,
        UOP_B_RD_IDX,
        UOP_P_B_WR,
        UOP_IDX_INC,
        UOP_CNT_DEC,
        UOP_Q_RD_CNT,
        UOP_Q_WR_HIT,
        UOP_MIN_UPD,
        UOP_SWAP0,
        UOP_SWAP1,
        UOP_NEXT_TAKE,
        UOP_Q_RD_LAST,
        UOP_Q_WR0_DEC,
        UOP_B_RD_A,
        UOP_C_LATCH,
        UOP_W_RD_IDX,
        UOP_C_W_WR,
        UOP_C_CLEAR,
        UOP_OUT_LOAD
    } uop_t;

    typedef struct packed {
        uop_t    uop;
        logic    set_status;
        status_t status;
    } cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic a_ok;
        logic b_ok;
        logic sched_a;
        logic self_dep;
        logic count_zero;
        logic count_gt1;
        logic full;
        logic idx_at_count;
        logic idx_at_ev;
        logic dmask_bit;
        logic bits_bit;
        logic match;
        logic found;
        logic hit_zero;
        logic out_busy;
    } stat_t;

endpackage

// File: design/dependency_event_scheduler.sv
// Top level of the dependency event scheduler: controller plus datapath.
//
//  Channel   Dir  Beat when           Contents
//  s_*       in   s_tvalid&s_tready   one operation (op in tuser, operands in tdata)
//  m_*       out  m_tvalid&m_tready   one result per operation
//
// Every operation passes through a latch state, a dispatch state and a result state;
// schedule and skip need nothing more. Chained schedule scans the queue for the
// second event; take-earliest scans the queue for the minimum and swaps it to the
// front; pause walks every event's mask bit, then scans the queue and removes the
// dependent if queued; complete walks every event for its dependents. The scans walk
// the single read port of the queue or dependency RAM one entry at a time.
// Reset clears tick, count, masks and the dependency valid bits at once; no sweep.
// A new beat is taken while a finished result waits; the block then stalls in its
// last cycle until the result is taken.
module dependency_event_scheduler #(
    parameter int EVENT_COUNT = 64,
    parameter int TICK_WIDTH  = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // event_sel, second_event, delay, dependee_mask, zero pad
    input  logic [des_pkg::IN_TDATA_W-1:0]  s_tdata,
    // op
    input  logic [des_pkg::IN_TUSER_W-1:0]  s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // out_event, out_tick, status, executed_count, zero pad
    output logic [des_pkg::OUT_TDATA_W-1:0] m_tdata
);

    des_pkg::cmd_t  cmd;
    des_pkg::stat_t stat;

    des_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    des_dpath #(
        .EVENT_COUNT (EVENT_COUNT),
        .TICK_WIDTH  (TICK_WIDTH)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

// File: design/des_ram.sv
// Generic single-write, single-read RAM with registered read data.
module des_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: design/des_dpath.sv
// Scheduler datapath: tick, queue, dependency memories and result register.
module des_dpath #(
    parameter int EVENT_COUNT = 64,
    parameter int TICK_WIDTH  = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [des_pkg::IN_TDATA_W-1:0]   s_tdata,
    input  logic [des_pkg::IN_TUSER_W-1:0]   s_tuser,
    input  logic                             m_tready,
    output logic                             m_tvalid,
    output logic [des_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input  des_pkg::cmd_t                    cmd,
    output des_pkg::stat_t                   stat
);

    localparam int EC = EVENT_COUNT;
    localparam int TW = TICK_WIDTH;
    localparam int AW = $clog2(EC);
    localparam int CW = $clog2(EC + 1);
    localparam int EW = des_pkg::EV_W;
    localparam int QW = TW + EW;
    localparam logic [EC-1:0] ONE = {{(EC-1){1'b0}}, 1'b1};
    localparam logic [EW:0]   EV_LIM = (EW+1)'(EC);
    localparam logic [CW-1:0] CNT_FULL = CW'(EC);

    // Latched input item.
    logic [des_pkg::OP_W-1:0]    op_reg;
    logic [EW-1:0]               a_reg;
    logic [EW-1:0]               b_reg;
    logic [des_pkg::DELAY_W-1:0] delay_reg;
    logic [EC-1:0]               dmask_reg;

    // Architectural state.
    logic [TW-1:0]               now_reg;
    logic [CW-1:0]               count_reg;
    logic [EC-1:0]               sched_reg;
    logic [des_pkg::EXEC_W-1:0]  exec_reg;
    logic [EC-1:0]               w_valid_reg;
    logic [EC-1:0]               b_valid_reg;
    logic                        w_rdv_reg;
    logic                        b_rdv_reg;

    // Working registers.
    logic [CW-1:0]               idx_reg;
    logic [AW-1:0]               hit_reg;
    logic                        found_reg;
    logic [TW-1:0]               min_due_reg;
    logic [EW-1:0]               min_ev_reg;
    logic [AW-1:0]               m_reg;
    logic [TW-1:0]               q0_due_reg;
    logic [EW-1:0]               q0_ev_reg;
    logic [EC-1:0]               bits_reg;
    logic [EW-1:0]               ev_out_reg;
    des_pkg::status_t            status_reg;

    // Result register.
    logic                        out_valid_reg;
    logic [EW-1:0]               out_ev_reg;
    logic [TW-1:0]               out_tick_reg;
    des_pkg::status_t            out_st_reg;
    logic [des_pkg::EXEC_W-1:0]  out_exec_reg;

    // Memory ports.
    logic          q_we;
    logic [AW-1:0] q_waddr;
    logic [QW-1:0] q_wdata;
    logic [AW-1:0] q_raddr;
    logic [QW-1:0] q_rdata;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [EC-1:0] w_wdata;
    logic [AW-1:0] w_raddr;
    logic [EC-1:0] w_rdata;
    logic          b_we;
    logic [AW-1:0] b_waddr;
    logic [EC-1:0] b_wdata;
    logic [AW-1:0] b_raddr;
    logic [EC-1:0] b_rdata;

    logic [TW+31:0] sum_wide;
    logic [TW-1:0]  tick_due;
    logic [EC-1:0]  bit_a;
    logic [EC-1:0]  bit_b;
    logic [EC-1:0]  bit_m;
    logic [TW-1:0]  q_rd_due;
    logic [EW-1:0]  q_rd_ev;
    logic [EC-1:0]  w_rd;
    logic [EC-1:0]  b_rd;
    logic [EC-1:0]  w_new;
    logic [AW-1:0]  a_a;
    logic [AW-1:0]  b_a;
    logic [AW-1:0]  idx_a;
    logic [AW-1:0]  cnt_a;
    logic [CW-1:0]  cnt_m1;
    logic           full;

    assign sum_wide = {32'b0, now_reg} + {{TW{1'b0}}, delay_reg};
    assign tick_due = sum_wide[TW-1:0];
    assign a_a      = a_reg[AW-1:0];
    assign b_a      = b_reg[AW-1:0];
    assign idx_a    = idx_reg[AW-1:0];
    assign cnt_a    = count_reg[AW-1:0];
    assign cnt_m1   = count_reg - 1'b1;
    assign bit_a    = ONE << a_a;
    assign bit_b    = ONE << b_a;
    assign bit_m    = ONE << min_ev_reg[AW-1:0];
    assign q_rd_due = q_rdata[TW-1:0];
    assign q_rd_ev  = q_rdata[QW-1:TW];
    // Entries never written read as zero.
    assign w_rd     = w_rdv_reg ? w_rdata : '0;
    assign b_rd     = b_rdv_reg ? b_rdata : '0;
    assign w_new    = w_rd & ~bit_a;
    assign full     = (count_reg == CNT_FULL);

    assign stat.op           = op_reg;
    assign stat.a_ok         = ({1'b0, a_reg} < EV_LIM);
    assign stat.b_ok         = ({1'b0, b_reg} < EV_LIM);
    assign stat.sched_a      = sched_reg[a_a];
    assign stat.self_dep     = dmask_reg[b_a];
    assign stat.count_zero   = (count_reg == '0);
    assign stat.count_gt1    = (count_reg > CW'(1));
    assign stat.full         = full;
    assign stat.idx_at_count = (idx_reg == count_reg);
    assign stat.idx_at_ev    = (idx_reg == CNT_FULL);
    assign stat.dmask_bit    = dmask_reg[idx_a];
    assign stat.bits_bit     = bits_reg[idx_a];
    assign stat.match        = (q_rd_ev == b_reg);
    assign stat.found        = found_reg;
    assign stat.hit_zero     = (hit_reg == '0);
    assign stat.out_busy     = out_valid_reg && !m_tready;

    always_comb
    begin
        q_we    = 1'b0;
        q_waddr = cnt_a;
        q_wdata = {a_reg, tick_due};
        q_raddr = idx_a;
        w_we    = 1'b0;
        w_waddr = b_a;
        w_wdata = w_rd | bit_a;
        w_raddr = b_a;
        b_we    = 1'b0;
        b_waddr = a_a;
        b_wdata = b_rd | bit_b;
        b_raddr = a_a;
        case (cmd.uop)
            des_pkg::UOP_SCHED_PUSH:
            begin
                q_we = 1'b1;
            end
            des_pkg::UOP_OVER_W_WR:
            begin
                w_we = 1'b1;
            end
            des_pkg::UOP_OVER_FIN:
            begin
                b_we    = 1'b1;
                q_we    = 1'b1;
                q_waddr = found_reg ? hit_reg : cnt_a;
            end
            des_pkg::UOP_P_W_WR:
            begin
                w_we    = 1'b1;
                w_wdata = w_rd | dmask_reg;
            end
            des_pkg::UOP_B_RD_IDX:
            begin
                b_raddr = idx_a;
            end
            des_pkg::UOP_P_B_WR:
            begin
                b_we    = 1'b1;
                b_waddr = idx_a;
            end
            des_pkg::UOP_Q_RD_CNT:
            begin
                q_raddr = cnt_a;
            end
            des_pkg::UOP_Q_WR_HIT:
            begin
                q_we    = 1'b1;
                q_waddr = hit_reg;
                q_wdata = q_rdata;
            end
            des_pkg::UOP_SWAP0:
            begin
                q_we    = 1'b1;
                q_waddr = '0;
                q_wdata = {min_ev_reg, min_due_reg};
            end
            des_pkg::UOP_SWAP1:
            begin
                q_we    = 1'b1;
                q_waddr = m_reg;
                q_wdata = {q0_ev_reg, q0_due_reg};
            end
            des_pkg::UOP_Q_RD_LAST:
            begin
                q_raddr = cnt_m1[AW-1:0];
            end
            des_pkg::UOP_Q_WR0_DEC:
            begin
                q_we    = 1'b1;
                q_waddr = '0;
                q_wdata = q_rdata;
            end
            des_pkg::UOP_W_RD_IDX:
            begin
                w_raddr = idx_a;
            end
            des_pkg::UOP_C_W_WR:
            begin
                w_we    = 1'b1;
                w_waddr = idx_a;
                w_wdata = w_new;
                // A dependent left with no dependee goes back on the queue unless the queue is full.
                if (w_new == '0 && !full)
                begin
                    q_we    = 1'b1;
                    q_wdata = {EW'(idx_a), now_reg};
                end
            end
            des_pkg::UOP_C_CLEAR:
            begin
                w_we    = 1'b1;
                w_waddr = a_a;
                w_wdata = '0;
                b_we    = 1'b1;
                b_wdata = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg       <= '0;
            count_reg     <= '0;
            sched_reg     <= '0;
            exec_reg      <= '0;
            w_valid_reg   <= '0;
            b_valid_reg   <= '0;
            w_rdv_reg     <= 1'b0;
            b_rdv_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            found_reg     <= 1'b0;
            status_reg    <= des_pkg::ST_OK;
        end
        else
        begin
            w_rdv_reg <= w_valid_reg[w_raddr];
            b_rdv_reg <= b_valid_reg[b_raddr];
            if (w_we)
            begin
                w_valid_reg[w_waddr] <= 1'b1;
            end
            if (b_we)
            begin
                b_valid_reg[b_waddr] <= 1'b1;
            end
            if (cmd.uop == des_pkg::UOP_OUT_LOAD)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.set_status)
            begin
                status_reg <= cmd.status;
            end
            case (cmd.uop)
                des_pkg::UOP_LATCH:
                begin
                    status_reg <= des_pkg::ST_OK;
                end
                des_pkg::UOP_SCHED_PUSH:
                begin
                    count_reg <= count_reg + 1'b1;
                    sched_reg <= sched_reg | bit_a;
                end
                des_pkg::UOP_SKIP:
                begin
                    now_reg <= tick_due;
                end
                des_pkg::UOP_SCAN_INIT:
                begin
                    idx_reg   <= '0;
                    found_reg <= 1'b0;
                end
                des_pkg::UOP_FIND_CMP:
                begin
                    if (q_rd_ev == b_reg)
                    begin
                        found_reg <= 1'b1;
                    end
                    idx_reg <= idx_reg + 1'b1;
                end
                des_pkg::UOP_OVER_FIN:
                begin
                    sched_reg <= (sched_reg & ~bit_b) | bit_a;
                    if (!found_reg)
                    begin
                        count_reg <= count_reg + 1'b1;
                    end
                end
                des_pkg::UOP_P_W_WR:
                begin
                    sched_reg <= sched_reg | bit_b;
                    idx_reg   <= '0;
                end
                des_pkg::UOP_P_B_WR,
                des_pkg::UOP_IDX_INC,
                des_pkg::UOP_MIN_UPD:
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
                des_pkg::UOP_CNT_DEC,
                des_pkg::UOP_Q_WR0_DEC:
                begin
                    count_reg <= count_reg - 1'b1;
                end
                des_pkg::UOP_Q_WR_HIT,
                des_pkg::UOP_C_LATCH:
                begin
                    idx_reg <= '0;
                end
                des_pkg::UOP_NEXT_TAKE:
                begin
                    now_reg   <= min_due_reg;
                    exec_reg  <= exec_reg + 1'b1;
                    sched_reg <= sched_reg & ~bit_m;
                end
                des_pkg::UOP_C_W_WR:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (w_new == '0)
                    begin
                        if (full)
                        begin
                            status_reg <= des_pkg::ST_FULL;
                        end
                        else
                        begin
                            count_reg <= count_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Payload registers, no reset.
    always_ff @(posedge clk)
    begin
        case (cmd.uop)
            des_pkg::UOP_LATCH:
            begin
                op_reg     <= s_tuser[des_pkg::OP_W-1:0];
                a_reg      <= s_tdata[des_pkg::IN_EV_LSB +: EW];
                b_reg      <= s_tdata[des_pkg::IN_SEC_LSB +: EW];
                delay_reg  <= s_tdata[des_pkg::IN_DLY_LSB +: des_pkg::DELAY_W];
                dmask_reg  <= s_tdata[des_pkg::IN_MASK_LSB +: EC];
                ev_out_reg <= '0;
            end
            des_pkg::UOP_FIND_CMP:
            begin
                if (q_rd_ev == b_reg && !found_reg)
                begin
                    hit_reg <= idx_a;
                end
            end
            des_pkg::UOP_MIN_UPD:
            begin
                // Strict compare keeps the first minimum in queue order.
                if (idx_reg == '0 || q_rd_due < min_due_reg)
                begin
                    min_due_reg <= q_rd_due;
                    min_ev_reg  <= q_rd_ev;
                    m_reg       <= idx_a;
                end
                if (idx_reg == '0)
                begin
                    q0_due_reg <= q_rd_due;
                    q0_ev_reg  <= q_rd_ev;
                end
            end
            des_pkg::UOP_NEXT_TAKE:
            begin
                ev_out_reg <= min_ev_reg;
            end
            des_pkg::UOP_C_LATCH:
            begin
                bits_reg <= b_rd;
            end
            des_pkg::UOP_OUT_LOAD:
            begin
                out_ev_reg   <= ev_out_reg;
                out_tick_reg <= now_reg;
                out_st_reg   <= status_reg;
                out_exec_reg <= exec_reg;
            end
            default:
            begin
            end
        endcase
    end

    des_ram #(
        .WIDTH (QW),
        .DEPTH (EC)
    ) u_queue_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

    des_ram #(
        .WIDTH (EC),
        .DEPTH (EC)
    ) u_waits_ram (
        .clk   (clk),
        .we    (w_we),
        .waddr (w_waddr),
        .wdata (w_wdata),
        .raddr (w_raddr),
        .rdata (w_rdata)
    );

    des_ram #(
        .WIDTH (EC),
        .DEPTH (EC)
    ) u_blocks_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (b_wdata),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(des_pkg::OUT_TDATA_W - des_pkg::OUT_USED_W){1'b0}},
                       out_exec_reg,
                       out_st_reg,
                       des_pkg::TICK_OUT_W'(out_tick_reg),
                       out_ev_reg};

endmodule

// File: design/des_ctrl.sv
// Scheduler controller: sequences each operation as datapath micro-operations.
module des_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  des_pkg::stat_t stat,
    output des_pkg::cmd_t  cmd
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISP,
        S_FIND,
        S_FIND_CMP,
        S_FIND_DONE,
        S_OVER_W,
        S_OVER_B,
        S_PW_WR,
        S_PB,
        S_PB_WR,
        S_P_RD,
        S_P_WR,
        S_MIN,
        S_MIN_CMP,
        S_SWAP0,
        S_SWAP1,
        S_NX_TAKE,
        S_NX_LAST,
        S_NX_WR,
        S_C_LATCH,
        S_C_LOOP,
        S_C_UPD,
        S_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ret_next_reg;
    logic   ret_next_next;

    always_comb
    begin
        state_next     = state_reg;
        ret_next_next  = ret_next_reg;
        s_tready       = 1'b0;
        cmd.uop        = des_pkg::UOP_NONE;
        cmd.set_status = 1'b0;
        cmd.status     = des_pkg::ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.uop    = des_pkg::UOP_LATCH;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                state_next = S_FIN;
                case (stat.op)
                    des_pkg::OP_SCHED:
                    begin
                        if (stat.a_ok)
                        begin
                            if (stat.sched_a)
                            begin
                                cmd.set_status = 1'b1;
                                cmd.status     = des_pkg::ST_DUP;
                            end
                            else if (stat.full)
                            begin
                                cmd.set_status = 1'b1;
                                cmd.status     = des_pkg::ST_FULL;
                            end
                            else
                            begin
                                cmd.uop = des_pkg::UOP_SCHED_PUSH;
                            end
                        end
                    end
                    des_pkg::OP_OVER:
                    begin
                        if (stat.a_ok && stat.b_ok)
                        begin
                            if (stat.sched_a)
                            begin
                                cmd.set_status = 1'b1;
                                cmd.status     = des_pkg::ST_DUP;
                            end
                            else
                            begin
                                cmd.uop    = des_pkg::UOP_SCAN_INIT;
                                state_next = S_FIND;
                            end
                        end
                    end
                    des_pkg::OP_PAUSE:
                    begin
                        if (stat.b_ok)
                        begin
                            if (stat.self_dep)
                            begin
                                cmd.set_status = 1'b1;
                                cmd.status     = des_pkg::ST_SELF;
                            end
                            else
                            begin
                                cmd.uop    = des_pkg::UOP_W_RD_B;
                                state_next = S_PW_WR;
                            end
                        end
                    end
                    des_pkg::OP_NEXT:
                    begin
                        if (stat.count_zero)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = des_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            cmd.uop       = des_pkg::UOP_SCAN_INIT;
                            ret_next_next = 1'b1;
                            state_next    = S_MIN;
                        end
                    end
                    des_pkg::OP_COMPLETE:
                    begin
                        if (stat.a_ok)
                        begin
                            cmd.uop    = des_pkg::UOP_B_RD_A;
                            state_next = S_C_LATCH;
                        end
                    end
                    des_pkg::OP_SKIP:
                    begin
                        if (stat.count_zero)
                        begin
                            cmd.uop = des_pkg::UOP_SKIP;
                        end
                        else
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = des_pkg::ST_REFUSED;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_FIND:
            begin
                if (stat.idx_at_count)
                begin
                    state_next = S_FIND_DONE;
                end
                else
                begin
                    cmd.uop    = des_pkg::UOP_Q_RD_IDX;
                    state_next = S_FIND_CMP;
                end
            end
            S_FIND_CMP:
            begin
                cmd.uop    = des_pkg::UOP_FIND_CMP;
                state_next = stat.match ? S_FIND_DONE : S_FIND;
            end
            S_FIND_DONE:
            begin
                state_next = S_FIN;
                if (stat.op == des_pkg::OP_OVER)
                begin
                    if (!stat.found && stat.full)
                    begin
                        cmd.set_status = 1'b1;
                        cmd.status     = des_pkg::ST_FULL;
                    end
                    else
                    begin
                        cmd.uop    = des_pkg::UOP_W_RD_B;
                        state_next = S_OVER_W;
                    end
                end
                else if (stat.found)
                begin
                    cmd.uop    = des_pkg::UOP_CNT_DEC;
                    state_next = S_P_RD;
                end
            end
            S_OVER_W:
            begin
                cmd.uop    = des_pkg::UOP_OVER_W_WR;
                state_next = S_OVER_B;
            end
            S_OVER_B:
            begin
                cmd.uop    = des_pkg::UOP_OVER_FIN;
                state_next = S_FIN;
            end
            S_PW_WR:
            begin
                cmd.uop    = des_pkg::UOP_P_W_WR;
                state_next = S_PB;
            end
            S_PB:
            begin
                if (stat.idx_at_ev)
                begin
                    cmd.uop    = des_pkg::UOP_SCAN_INIT;
                    state_next = S_FIND;
                end
                else if (stat.dmask_bit)
                begin
                    cmd.uop    = des_pkg::UOP_B_RD_IDX;
                    state_next = S_PB_WR;
                end
                else
                begin
                    cmd.uop = des_pkg::UOP_IDX_INC;
                end
            end
            S_PB_WR:
            begin
                cmd.uop    = des_pkg::UOP_P_B_WR;
                state_next = S_PB;
            end
            S_P_RD:
            begin
                cmd.uop    = des_pkg::UOP_Q_RD_CNT;
                state_next = S_P_WR;
            end
            S_P_WR:
            begin
                cmd.uop = des_pkg::UOP_Q_WR_HIT;
                // The head moved, so the minimum goes back to the front.
                if (stat.hit_zero)
                begin
                    ret_next_next = 1'b0;
                    state_next    = S_MIN;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_MIN:
            begin
                if (stat.idx_at_count)
                begin
                    state_next = stat.count_zero ? S_FIN : S_SWAP0;
                end
                else
                begin
                    cmd.uop    = des_pkg::UOP_Q_RD_IDX;
                    state_next = S_MIN_CMP;
                end
            end
            S_MIN_CMP:
            begin
                cmd.uop    = des_pkg::UOP_MIN_UPD;
                state_next = S_MIN;
            end
            S_SWAP0:
            begin
                cmd.uop    = des_pkg::UOP_SWAP0;
                state_next = S_SWAP1;
            end
            S_SWAP1:
            begin
                cmd.uop    = des_pkg::UOP_SWAP1;
                state_next = ret_next_reg ? S_NX_TAKE : S_FIN;
            end
            S_NX_TAKE:
            begin
                cmd.uop    = des_pkg::UOP_NEXT_TAKE;
                state_next = S_NX_LAST;
            end
            S_NX_LAST:
            begin
                if (stat.count_gt1)
                begin
                    cmd.uop    = des_pkg::UOP_Q_RD_LAST;
                    state_next = S_NX_WR;
                end
                else
                begin
                    cmd.uop    = des_pkg::UOP_CNT_DEC;
                    state_next = S_FIN;
                end
            end
            S_NX_WR:
            begin
                cmd.uop    = des_pkg::UOP_Q_WR0_DEC;
                state_next = S_FIN;
            end
            S_C_LATCH:
            begin
                cmd.uop    = des_pkg::UOP_C_LATCH;
                state_next = S_C_LOOP;
            end
            S_C_LOOP:
            begin
                if (stat.idx_at_ev)
                begin
                    cmd.uop    = des_pkg::UOP_C_CLEAR;
                    state_next = S_FIN;
                end
                else if (stat.bits_bit)
                begin
                    cmd.uop    = des_pkg::UOP_W_RD_IDX;
                    state_next = S_C_UPD;
                end
                else
                begin
                    cmd.uop = des_pkg::UOP_IDX_INC;
                end
            end
            S_C_UPD:
            begin
                cmd.uop    = des_pkg::UOP_C_W_WR;
                state_next = S_C_LOOP;
            end
            S_FIN:
            begin
                if (!stat.out_busy)
                begin
                    cmd.uop    = des_pkg::UOP_OUT_LOAD;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            ret_next_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            ret_next_reg <= ret_next_next;
        end
    end

endmodule

// File: design/des_checks.sv
// Port-level checks for the dependency event scheduler, bound to the top level.
module des_checks (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [des_pkg::OUT_TDATA_W-1:0] m_tdata
);

    logic [1:0]                 pend_reg;
    logic                       have_prev_reg;
    logic [des_pkg::EXEC_W-1:0] prev_exec_reg;
    logic                       in_beat;
    logic                       out_beat;
    logic [des_pkg::ST_W-1:0]   st;
    logic [des_pkg::EV_W-1:0]   ev;
    logic [des_pkg::EXEC_W-1:0] exec_cnt;
    logic [des_pkg::EXEC_W-1:0] exec_step;

    assign in_beat   = s_tvalid && s_tready;
    assign out_beat  = m_tvalid && m_tready;
    assign st        = m_tdata[des_pkg::OUT_ST_LSB +: des_pkg::ST_W];
    assign ev        = m_tdata[des_pkg::OUT_EV_LSB +: des_pkg::EV_W];
    assign exec_cnt  = m_tdata[des_pkg::OUT_EXEC_LSB +: des_pkg::EXEC_W];
    assign exec_step = exec_cnt - prev_exec_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= '0;
            have_prev_reg <= 1'b0;
            prev_exec_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_reg + {1'b0, in_beat} - {1'b0, out_beat};
            if (out_beat)
            begin
                have_prev_reg <= 1'b1;
                prev_exec_reg <= exec_cnt;
            end
        end
    end

    // A stalled result beat keeps its contents.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // No result without an operation taken before it.
    a_cause: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> pend_reg != 2'd0)
        else $error("result beat with no operation outstanding");

    // At most one operation in work besides one waiting result.
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |-> pend_reg != 2'd2)
        else $error("operation taken with two already outstanding");

    // A result with an error status names no event.
    a_event: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && st != des_pkg::ST_OK |-> ev == '0)
        else $error("event reported with an error status");

    // The executed count moves by at most one per result.
    a_exec: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && have_prev_reg |-> exec_step == '0 || exec_step == des_pkg::EXEC_W'(1))
        else $error("executed count jumped");

endmodule

bind dependency_event_scheduler des_checks u_checks (.*);
